// ----- rtl/core/blf_pkg.sv -----
// blf_pkg: shared types, codes and sizes of the blocklist frame filter
// no dependencies; imported by every module under rtl/core but blf_ram
package blf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_OUT_W   = 11;
    localparam int CNT_OUT_MAX = 2047;

    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // request codes
    localparam logic [1:0] REQ_FRAME  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VPN_PORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TLS_PORT = 2'd1;

    localparam logic [PORT_W-1:0] VPN_PORT_RST = 16'd51820;
    localparam logic [PORT_W-1:0] TLS_PORT_RST = 16'd853;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_TABLE   = 1'b1;

    // drop causes
    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_ADDR = 2'd1;
    localparam logic [1:0] CAUSE_VPN  = 2'd2;
    localparam logic [1:0] CAUSE_TLS  = 2'd3;

    // table status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;

    // frame parse
    localparam logic [5:0]  POS_MAX     = 6'd63;
    localparam logic [5:0]  POS_ET_HI   = 6'd12;
    localparam logic [5:0]  POS_ET_LO   = 6'd13;
    localparam logic [5:0]  POS_PROTO   = 6'd23;
    localparam logic [5:0]  POS_DA_0    = 6'd30;
    localparam logic [5:0]  POS_DA_1    = 6'd31;
    localparam logic [5:0]  POS_DA_2    = 6'd32;
    localparam logic [5:0]  POS_DA_3    = 6'd33;
    localparam logic [5:0]  POS_DP_HI   = 6'd36;
    localparam logic [5:0]  POS_DP_LO   = 6'd37;
    localparam logic [6:0]  LEN_IPV4    = 7'd34;
    localparam logic [6:0]  LEN_UDP     = 7'd42;
    localparam logic [6:0]  LEN_TCP     = 7'd54;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;

    typedef enum logic [1:0] {
        CMD_VERDICT = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_REMOVE  = 2'd2
    } cmd_kind_t;

    // one classified item handed from front to back
    typedef struct packed {
        cmd_kind_t         kind;
        logic              check_addr;
        logic [1:0]        port_cause;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_OUT_W-1:0] r;
        if (c > CNT_W'(CNT_OUT_MAX))
            r = CNT_OUT_W'(CNT_OUT_MAX);
        else
            r = CNT_OUT_W'(c);
        return r;
    endfunction

endpackage

// ----- rtl/core/blf_ram.sv -----
// blf_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module blf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/blf_front.sv -----
// blf_front: config registers, frame byte parser and request classifier
// depends on blf_pkg; pushes cmd_t items into blf_queue
module blf_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     req_type,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [blf_pkg::ADDR_W-1:0]     address,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [blf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blf_pkg::PORT_W-1:0]     cfg_data,
    input  logic                           q_full,
    output logic                           cmd_push,
    output blf_pkg::cmd_t                  cmd
);
    import blf_pkg::*;

    logic [PORT_W-1:0] vpn_port_reg;
    logic [PORT_W-1:0] tls_port_reg;

    logic [5:0]        pos_reg,   pos_next;
    logic [15:0]       et_reg,    et_next;
    logic [7:0]        proto_reg, proto_next;
    logic [ADDR_W-1:0] da_reg,    da_next;
    logic [PORT_W-1:0] dp_reg,    dp_next;

    logic [15:0]       et_cur;
    logic [7:0]        proto_cur;
    logic [ADDR_W-1:0] da_cur;
    logic [PORT_W-1:0] dp_cur;
    logic [6:0]        len;
    logic              ipv4_ok;
    logic [1:0]        port_cause;
    logic              accept;

    assign busy      = q_full;
    assign accept    = start & ~q_full;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpn_port_reg <= VPN_PORT_RST;
            tls_port_reg <= TLS_PORT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VPN_PORT: vpn_port_reg <= cfg_data;
                CFG_TLS_PORT: tls_port_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // header fields with the current byte merged in
    always_comb
    begin
        et_cur    = et_reg;
        proto_cur = proto_reg;
        da_cur    = da_reg;
        dp_cur    = dp_reg;
        case (pos_reg)
            POS_ET_HI: et_cur[15:8] = data_byte;
            POS_ET_LO: et_cur[7:0]  = data_byte;
            POS_PROTO: proto_cur    = data_byte;
            POS_DA_0, POS_DA_1, POS_DA_2, POS_DA_3:
                da_cur = {da_reg[ADDR_W-9:0], data_byte};
            POS_DP_HI: dp_cur[15:8] = data_byte;
            POS_DP_LO: dp_cur[7:0]  = data_byte;
            default:   ;
        endcase
    end

    always_comb
    begin
        len     = {1'b0, pos_reg} + 7'd1;
        ipv4_ok = (len >= LEN_IPV4) && (et_cur == ETYPE_IPV4);
        port_cause = CAUSE_NONE;
        if (ipv4_ok)
        begin
            if (proto_cur == PROTO_UDP)
            begin
                if (len >= LEN_UDP && dp_cur == vpn_port_reg)
                    port_cause = CAUSE_VPN;
            end
            else if (proto_cur == PROTO_TCP)
            begin
                if (len >= LEN_TCP && dp_cur == tls_port_reg)
                    port_cause = CAUSE_TLS;
            end
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        et_next    = et_reg;
        proto_next = proto_reg;
        da_next    = da_reg;
        dp_next    = dp_reg;
        cmd_push   = 1'b0;
        cmd.kind       = CMD_VERDICT;
        cmd.check_addr = ipv4_ok;
        cmd.port_cause = port_cause;
        cmd.addr       = da_cur;
        if (accept)
        begin
            case (req_type)
                REQ_FRAME:
                begin
                    if (last_byte)
                    begin
                        cmd_push   = 1'b1;
                        pos_next   = '0;
                        et_next    = '0;
                        proto_next = '0;
                        da_next    = '0;
                        dp_next    = '0;
                    end
                    else
                    begin
                        et_next    = et_cur;
                        proto_next = proto_cur;
                        da_next    = da_cur;
                        dp_next    = dp_cur;
                        if (pos_reg != POS_MAX)
                            pos_next = pos_reg + 6'd1;
                    end
                end
                REQ_ADD, REQ_REMOVE:
                begin
                    cmd_push       = 1'b1;
                    cmd.kind       = (req_type == REQ_ADD) ? CMD_ADD : CMD_REMOVE;
                    cmd.check_addr = 1'b1;
                    cmd.port_cause = CAUSE_NONE;
                    cmd.addr       = address;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            et_reg    <= '0;
            proto_reg <= '0;
            da_reg    <= '0;
            dp_reg    <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            et_reg    <= et_next;
            proto_reg <= proto_next;
            da_reg    <= da_next;
            dp_reg    <= dp_next;
        end
    end

endmodule

// ----- rtl/core/blf_queue.sv -----
// blf_queue: short in-order queue of classified items between front and back
// depends on blf_pkg
module blf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  blf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output blf_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import blf_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   cnt_reg,    cnt_next;

    assign full  = (cnt_reg == QC_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
    a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue full and empty at once");
`endif

endmodule

// ----- rtl/core/blf_back.sv -----
// blf_back: blocklist scan, table update and result registers
// depends on blf_pkg and blf_ram; pops cmd_t items from blf_queue
module blf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  blf_pkg::cmd_t                  q_head,
    output logic                           q_pop,
    output logic                           result_valid,
    output logic                           result_kind,
    output logic                           drop,
    output logic [1:0]                     drop_cause,
    output logic [1:0]                     table_status,
    output logic [blf_pkg::CNT_OUT_W-1:0]  entry_count
);
    import blf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_EXEC    = 5'b00100,
        ST_MOVE_RD = 5'b01000,
        ST_MOVE_WR = 5'b10000
    } back_state_t;

    back_state_t          state_reg,    state_next;
    cmd_t                 cmd_reg,      cmd_next;
    logic [CNT_W-1:0]     count_reg,    count_next;
    logic [CNT_W-1:0]     issue_reg,    issue_next;
    logic                 pend_reg,     pend_next;
    logic [TBL_AW-1:0]    pend_idx_reg, pend_idx_next;
    logic                 found_reg,    found_next;
    logic [TBL_AW-1:0]    found_idx_reg, found_idx_next;

    logic                 res_valid_reg, res_valid_next;
    logic                 res_kind_reg,  res_kind_next;
    logic                 drop_reg,      drop_next;
    logic [1:0]           cause_reg,     cause_next;
    logic [1:0]           status_reg,    status_next;
    logic [CNT_OUT_W-1:0] ecount_reg,    ecount_next;

    logic                 wr_en;
    logic [TBL_AW-1:0]    wr_addr;
    logic [ADDR_W-1:0]    wr_data;
    logic                 rd_en;
    logic [TBL_AW-1:0]    rd_addr;
    logic [ADDR_W-1:0]    rd_data;
    logic [CNT_W-1:0]     last_cnt;

    // entries 0 .. count-1 hold the list, kept packed by moving the tail on removal
    blf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign last_cnt = count_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        res_valid_next = 1'b0;
        res_kind_next  = res_kind_reg;
        drop_next      = drop_reg;
        cause_next     = cause_reg;
        status_next    = status_reg;
        ecount_next    = ecount_reg;
        q_pop   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = count_reg[TBL_AW-1:0];
        wr_data = cmd_reg.addr;
        rd_en   = 1'b0;
        rd_addr = issue_reg[TBL_AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    issue_next = '0;
                    found_next = 1'b0;
                    if (q_head.kind == CMD_VERDICT && !q_head.check_addr)
                        state_next = ST_EXEC;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[TBL_AW-1:0];
                end
                if (pend_reg && rd_data == cmd_reg.addr)
                begin
                    found_next     = 1'b1;
                    found_idx_next = pend_idx_reg;
                    state_next     = ST_EXEC;
                end
                else if (!pend_reg && issue_reg >= count_reg)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (cmd_reg.kind)
                    CMD_VERDICT:
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = KIND_VERDICT;
                        cause_next     = found_reg ? CAUSE_ADDR : cmd_reg.port_cause;
                        drop_next      = found_reg || (cmd_reg.port_cause != CAUSE_NONE);
                        status_next    = STAT_DONE;
                        ecount_next    = sat_count(count_reg);
                    end
                    CMD_ADD:
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = KIND_TABLE;
                        cause_next     = CAUSE_NONE;
                        drop_next      = 1'b0;
                        status_next    = STAT_DONE;
                        if (!found_reg)
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ecount_next = sat_count(count_next);
                    end
                    CMD_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            state_next = ST_MOVE_RD;
                        end
                        else
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_TABLE;
                            cause_next     = CAUSE_NONE;
                            drop_next      = 1'b0;
                            status_next    = STAT_ABSENT;
                            ecount_next    = sat_count(count_reg);
                        end
                    end
                    default: ;
                endcase
            end
            ST_MOVE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_cnt[TBL_AW-1:0];
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                wr_en          = 1'b1;
                wr_addr        = found_idx_reg;
                wr_data        = rd_data;
                count_next     = last_cnt;
                res_valid_next = 1'b1;
                res_kind_next  = KIND_TABLE;
                cause_next     = CAUSE_NONE;
                drop_next      = 1'b0;
                status_next    = STAT_DONE;
                ecount_next    = sat_count(last_cnt);
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_idx_reg  <= pend_idx_next;
        found_idx_reg <= found_idx_next;
        res_kind_reg  <= res_kind_next;
        drop_reg      <= drop_next;
        cause_reg     <= cause_next;
        status_reg    <= status_next;
        ecount_reg    <= ecount_next;
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign drop         = drop_reg;
    assign drop_cause   = cause_reg;
    assign table_status = status_reg;
    assign entry_count  = ecount_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("blocklist count beyond table depth");
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_EXEC) || (state_reg == ST_MOVE_WR))
        else $error("table write outside update states");
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_next |=> result_valid && (count_reg <= $past(count_reg) + 1'b1))
        else $error("result strobe or count step wrong");
`endif

endmodule

// ----- rtl/core/packet_blocklist_filter.sv -----
// packet_blocklist_filter: top level of the ipv4 destination and port drop filter
// depends on blf_pkg, blf_front, blf_queue, blf_back (blf_back holds blf_ram)
//
//  channel   signals                                          transfer when
//  -------   -----------------------------------------------  ----------------------
//  request   start, busy, req_type, data_byte, last_byte,     start & !busy
//            address
//  result    result_valid, result_kind, drop, drop_cause,     result_valid (1 cycle)
//            table_status, entry_count
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid & cfg_ready
//
//  a frame byte is merged into the parser registers as it is taken; the back end pops a
//  request, scans the held entries up to a match on the registered read port of the table
//  ram, then executes; a found removal adds a tail read and a tail write
//  reset empties the list through the fill count alone; no clearing pass is run
//  busy is high while the two-entry queue between parser and back end is full
//  results are strobed for one cycle; the receiver cannot stall them
module packet_blocklist_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     req_type,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [blf_pkg::ADDR_W-1:0]     address,
    // result channel
    output logic                           result_valid,
    output logic                           result_kind,
    output logic                           drop,
    output logic [1:0]                     drop_cause,
    output logic [1:0]                     table_status,
    output logic [blf_pkg::CNT_OUT_W-1:0]  entry_count,
    // config channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [blf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blf_pkg::PORT_W-1:0]     cfg_data
);
    import blf_pkg::*;

    // classified items from parser to back end
    cmd_t front_cmd;
    logic front_push;
    cmd_t q_head;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // parser: captures header fields, checks ports, classifies each request
    blf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .address   (address),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    // keeps request order so results leave in arrival order
    blf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end: blocklist search and update, registered result
    blf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .drop         (drop),
        .drop_cause   (drop_cause),
        .table_status (table_status),
        .entry_count  (entry_count)
    );

endmodule

// ----- test/packet_blocklist_filter_checker.sv -----
// packet_blocklist_filter_checker: tracks frame parse, blocklist and port registers of the
// filter, predicts each verdict and table status and compares it with the result channel
// depends on blf_pkg for codes and widths; instantiated by packet_blocklist_filter_tb
module packet_blocklist_filter_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic [blf_pkg::ADDR_W-1:0]    address,
    input  logic                          result_valid,
    input  logic                          result_kind,
    input  logic                          drop,
    input  logic [1:0]                    drop_cause,
    input  logic [1:0]                    table_status,
    input  logic [blf_pkg::CNT_OUT_W-1:0] entry_count,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [blf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [blf_pkg::PORT_W-1:0]    cfg_data,
    output int                            mismatch_total,
    output int                            outcomes_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import blf_pkg::*;

    // byte offsets in the frame and lengths each check needs
    localparam int AT_ETYPE_HI   = 12;
    localparam int AT_ETYPE_LO   = 13;
    localparam int AT_PROTO      = 23;
    localparam int AT_DEST_FIRST = 30;
    localparam int AT_DEST_LAST  = 33;
    localparam int AT_PORT_HI    = 36;
    localparam int AT_PORT_LO    = 37;
    localparam int NEED_IPV4     = 34;
    localparam int NEED_UDP      = 42;
    localparam int NEED_TCP      = 54;
    localparam int POS_CEIL      = 63;
    localparam int COUNT_CEIL    = (1 << CNT_OUT_W) - 1;

    typedef struct packed {
        logic                 kind;
        logic                 drop;
        logic [1:0]           cause;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] count;
    } outcome_t;

    outcome_t          outcomes_due[$];
    logic [PORT_W-1:0] vpn_port_reg;
    logic [PORT_W-1:0] tls_port_reg;
    logic [5:0]        parse_pos;
    logic [15:0]       seen_etype;
    logic [7:0]        seen_proto;
    logic [31:0]       seen_dest;
    logic [15:0]       seen_port;
    bit                blocked_set[bit [31:0]];
    int                blocked_count;
    int                mismatches = 0;
    int                due_count;

    assign mismatch_total   = mismatches;
    assign outcomes_pending = due_count;

    function automatic logic [CNT_OUT_W-1:0] count_view();
        return (blocked_count > COUNT_CEIL) ? CNT_OUT_W'(COUNT_CEIL)
                                            : CNT_OUT_W'(blocked_count);
    endfunction

    task automatic judge_frame_byte(input logic [7:0] b, input logic is_last);
        int       len;
        outcome_t o;
        if (parse_pos == AT_ETYPE_HI)
            seen_etype[15:8] = b;
        else if (parse_pos == AT_ETYPE_LO)
            seen_etype[7:0] = b;
        else if (parse_pos == AT_PROTO)
            seen_proto = b;
        else if (parse_pos >= AT_DEST_FIRST && parse_pos <= AT_DEST_LAST)
            seen_dest = {seen_dest[23:0], b};
        else if (parse_pos == AT_PORT_HI)
            seen_port[15:8] = b;
        else if (parse_pos == AT_PORT_LO)
            seen_port[7:0] = b;
        if (!is_last)
        begin
            if (parse_pos < POS_CEIL)
                parse_pos = parse_pos + 6'd1;
            return;
        end
        len = int'(parse_pos) + 1;
        o = '0;
        o.kind   = KIND_VERDICT;
        o.cause  = CAUSE_NONE;
        o.status = STAT_DONE;
        if (len >= NEED_IPV4 && seen_etype == ETYPE_IPV4)
        begin
            if (blocked_set.exists(seen_dest))
                o.cause = CAUSE_ADDR;
            else if (seen_proto == PROTO_UDP)
            begin
                if (len >= NEED_UDP && seen_port == vpn_port_reg)
                    o.cause = CAUSE_VPN;
            end
            else if (seen_proto == PROTO_TCP)
            begin
                if (len >= NEED_TCP && seen_port == tls_port_reg)
                    o.cause = CAUSE_TLS;
            end
        end
        o.drop  = (o.cause != CAUSE_NONE);
        o.count = count_view();
        outcomes_due.push_back(o);
        parse_pos  = '0;
        seen_etype = '0;
        seen_proto = '0;
        seen_dest  = '0;
        seen_port  = '0;
    endtask

    task automatic serve_table_request(input logic [1:0] req, input bit [31:0] a);
        outcome_t o;
        o = '0;
        o.kind   = KIND_TABLE;
        o.cause  = CAUSE_NONE;
        o.status = STAT_DONE;
        if (req == REQ_ADD)
        begin
            if (!blocked_set.exists(a))
            begin
                if (blocked_count >= TABLE_DEPTH)
                    o.status = STAT_FULL;
                else
                begin
                    blocked_set[a] = 1'b1;
                    blocked_count++;
                end
            end
        end
        else if (blocked_set.exists(a))
        begin
            blocked_set.delete(a);
            blocked_count--;
        end
        else
            o.status = STAT_ABSENT;
        o.count = count_view();
        outcomes_due.push_back(o);
    endtask

    task automatic check_result();
        outcome_t e;
        bit       bad;
        if (outcomes_due.size() == 0)
        begin
            $error("result with nothing outstanding: kind %0d drop %0d cause %0d",
                   result_kind, drop, drop_cause);
            $error("result with nothing outstanding: status %0d count %0d",
                   table_status, entry_count);
            mismatches++;
            return;
        end
        e = outcomes_due.pop_front();
        bad = 1'b0;
        if (result_kind !== e.kind)
        begin
            $error("result_kind: expected %0d, got %0d", e.kind, result_kind);
            bad = 1'b1;
        end
        if (drop !== e.drop)
        begin
            $error("drop: expected %0d, got %0d", e.drop, drop);
            bad = 1'b1;
        end
        if (drop_cause !== e.cause)
        begin
            $error("drop_cause: expected %0d, got %0d", e.cause, drop_cause);
            bad = 1'b1;
        end
        if (table_status !== e.status)
        begin
            $error("table_status: expected %0d, got %0d", e.status, table_status);
            bad = 1'b1;
        end
        if (entry_count !== e.count)
        begin
            $error("entry_count: expected %0d, got %0d", e.count, entry_count);
            bad = 1'b1;
        end
        if (bad)
            mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outcomes_due.delete();
            blocked_set.delete();
            blocked_count = 0;
            vpn_port_reg  = VPN_PORT_RST;
            tls_port_reg  = TLS_PORT_RST;
            parse_pos     = '0;
            seen_etype    = '0;
            seen_proto    = '0;
            seen_dest     = '0;
            seen_port     = '0;
            due_count    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_VPN_PORT)
                    vpn_port_reg = cfg_data;
                else if (cfg_index == CFG_TLS_PORT)
                    tls_port_reg = cfg_data;
            end
            // a result never belongs to a request taken at the same edge
            if (result_valid !== 1'b0)
                check_result();
            if (start && !busy)
            begin
                if (req_type == REQ_FRAME)
                    judge_frame_byte(data_byte, last_byte);
                else if (req_type == REQ_ADD || req_type == REQ_REMOVE)
                    serve_table_request(req_type, address);
            end
            due_count <= outcomes_due.size();
        end
    end

endmodule

// ----- test/packet_blocklist_filter_tb.sv -----
// packet_blocklist_filter_tb: clock, reset and stimulus for the blocklist frame filter
// depends on blf_pkg, packet_blocklist_filter and packet_blocklist_filter_checker
module packet_blocklist_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import blf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 480;
    localparam int QUIET_LIMIT   = 10000;
    // wait for the parser to settle after the last result, with a little margin on top
    localparam int SETTLE_CYCLES = 16;
    // keeps the blocklist short during random traffic so lookups stay fast
    localparam int POOL_CAP      = 32;

    localparam logic [1:0]           REQ_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3  = 2'd3;
    localparam logic [15:0]          ETYPE_IPV6   = 16'h86DD;
    localparam logic [7:0]           PROTO_ICMP   = 8'd1;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           req_type;
    logic [7:0]           data_byte;
    logic                 last_byte;
    logic [ADDR_W-1:0]    address;
    logic                 result_valid;
    logic                 result_kind;
    logic                 drop;
    logic [1:0]           drop_cause;
    logic [1:0]           table_status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PORT_W-1:0]    cfg_data;

    int mismatches;
    int pending;
    int quiet_cycles;

    // stimulus bookkeeping
    logic [7:0]  frame_buf[0:127];
    int          frame_len;
    logic [31:0] addr_pool[$];
    logic [15:0] cur_vpn;
    logic [15:0] cur_tls;
    logic [31:0] fill_salt;
    bit          steady;
    bit          noisy;
    int          items_sent;

    packet_blocklist_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .address      (address),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .drop         (drop),
        .drop_cause   (drop_cause),
        .table_status (table_status),
        .entry_count  (entry_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    packet_blocklist_filter_checker outcome_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .address          (address),
        .result_valid     (result_valid),
        .result_kind      (result_kind),
        .drop             (drop),
        .drop_cause       (drop_cause),
        .table_status     (table_status),
        .entry_count      (entry_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_total   (mismatches),
        .outcomes_pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // one request transfer; start stays high so back to back items need no re-raise
    task automatic issue(input logic [1:0] kind, input logic [7:0] b, input logic lst,
                         input logic [31:0] a);
        int gap;
        int r;
        gap = 0;
        if (!steady)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 98)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= kind;
        data_byte <= b;
        last_byte <= lst;
        address   <= a;
        do @(posedge clk); while (busy);
        if (kind != REQ_RESERVED)
            items_sent++;
    endtask

    // table requests carry random frame fields, which the block must ignore
    task automatic issue_table(input logic [1:0] kind, input logic [31:0] a);
        issue(kind, 8'($urandom), 1'($urandom), a);
    endtask

    task automatic random_table_request();
        logic [1:0]  kind;
        logic [31:0] a;
        kind = $urandom_range(0, 1) ? REQ_ADD : REQ_REMOVE;
        if (addr_pool.size() != 0 && $urandom_range(0, 99) < 80)
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        else
        begin
            a = $urandom;
            if (kind == REQ_ADD)
            begin
                // only pooled addresses ever get added, so the list stays bounded
                if (addr_pool.size() < POOL_CAP)
                    addr_pool.push_back(a);
                else
                    kind = REQ_REMOVE;
            end
        end
        issue_table(kind, a);
    endtask

    // random frame body with the parsed header fields laid over it
    task automatic build_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                               input logic [31:0] dest, input logic [15:0] port);
        foreach (frame_buf[i])
            frame_buf[i] = 8'($urandom);
        frame_buf[POS_ET_HI] = etype[15:8];
        frame_buf[POS_ET_LO] = etype[7:0];
        frame_buf[POS_PROTO] = proto;
        frame_buf[POS_DA_0]  = dest[31:24];
        frame_buf[POS_DA_1]  = dest[23:16];
        frame_buf[POS_DA_2]  = dest[15:8];
        frame_buf[POS_DA_3]  = dest[7:0];
        frame_buf[POS_DP_HI] = port[15:8];
        frame_buf[POS_DP_LO] = port[7:0];
        frame_len = len;
    endtask

    // bytes first..upto-1 of the built frame, with table requests and
    // reserved items slipped in between bytes when noisy
    task automatic send_frame_span(input int first, input int upto);
        int r;
        for (int i = first; i < upto; i++)
        begin
            if (noisy)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    random_table_request();
                else if (r == 3)
                    issue(REQ_RESERVED, 8'($urandom), 1'($urandom), $urandom);
            end
            issue(REQ_FRAME, frame_buf[i], (i == frame_len - 1), $urandom);
        end
    endtask

    task automatic send_frame();
        send_frame_span(0, frame_len);
    endtask

    task automatic random_frame();
        int          r;
        int          len;
        logic [15:0] etype;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [31:0] dest;
        r = $urandom_range(0, 99);
        if (r < 6)
            len = $urandom_range(1, 13);
        else if (r < 16)
            len = $urandom_range(14, 33);
        else if (r < 36)
        begin
            // lengths right at the edges of each check
            case ($urandom_range(0, 5))
                0: len = 33;
                1: len = 34;
                2: len = 41;
                3: len = 42;
                4: len = 53;
                default: len = 54;
            endcase
        end
        else if (r < 92)
            len = $urandom_range(34, 64);
        else
            len = $urandom_range(65, 100);
        etype = ($urandom_range(0, 99) < 85) ? ETYPE_IPV4 : 16'($urandom);
        r = $urandom_range(0, 99);
        proto = (r < 40) ? PROTO_UDP : (r < 80) ? PROTO_TCP : 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45)
            port = (proto == PROTO_TCP) ? cur_tls : cur_vpn;
        else if (r < 60)
            port = (proto == PROTO_TCP) ? cur_vpn : cur_tls;
        else
            port = 16'($urandom);
        if (addr_pool.size() != 0 && $urandom_range(0, 99) < 40)
            dest = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        else
            dest = $urandom;
        build_frame(len, etype, proto, dest, port);
        // some frames go out with no gaps at all
        steady = ($urandom_range(0, 99) < 20);
        send_frame();
    endtask

    task automatic run_random(input int n);
        int goal;
        goal  = items_sent + n;
        noisy = 1'b1;
        while (items_sent < goal)
        begin
            repeat ($urandom_range(0, 2)) random_table_request();
            random_frame();
        end
        noisy  = 1'b0;
        steady = 1'b0;
    endtask

    // drop start, wait for every outstanding result, then let the parser settle
    task automatic quiesce();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx, input logic [PORT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // both port registers plus the unused indexes, which must have no effect
    task automatic program_ports(input logic [15:0] vpn, input logic [15:0] tls);
        cfg_transfer(CFG_VPN_PORT, vpn);
        cfg_transfer(CFG_TLS_PORT, tls);
        cfg_transfer(CFG_SPARE_2, 16'($urandom));
        cfg_transfer(CFG_SPARE_3, 16'($urandom));
        cfg_valid <= 1'b0;
        cur_vpn = vpn;
        cur_tls = tls;
    endtask

    // distinct addresses for filling the table: odd multiply is one to one
    function automatic logic [31:0] fill_addr(input int k);
        return (32'(k) * 32'h9E37_79B1) ^ fill_salt;
    endfunction

    initial
    begin
        logic [31:0] probe;
        logic [15:0] same_port;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= REQ_FRAME;
        data_byte  <= 8'h00;
        last_byte  <= 1'b0;
        address    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_VPN_PORT;
        cfg_data   <= '0;
        cur_vpn    = VPN_PORT_RST;
        cur_tls    = TLS_PORT_RST;
        steady     = 1'b0;
        noisy      = 1'b0;
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: table corner cases at the address extremes and removal of an absent address
        issue_table(REQ_ADD, 32'h0000_0000);
        issue_table(REQ_ADD, 32'hFFFF_FFFF);
        issue_table(REQ_ADD, 32'hFFFF_FFFF);
        issue_table(REQ_REMOVE, 32'h0A00_0001);
        addr_pool.push_back(32'h0000_0000);
        addr_pool.push_back(32'hFFFF_FFFF);
        issue(REQ_RESERVED, 8'hFF, 1'b1, 32'hFFFF_FFFF);

        // directed: frame lengths around each check, reset port values
        build_frame(1, ETYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, cur_vpn);
        send_frame();
        build_frame(13, ETYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, cur_vpn);
        send_frame();
        build_frame(33, ETYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, cur_vpn);
        send_frame();
        build_frame(34, ETYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, cur_vpn);
        send_frame();
        // blocked address but not ipv4
        build_frame(60, ETYPE_IPV6, PROTO_UDP, 32'hFFFF_FFFF, cur_vpn);
        send_frame();
        build_frame(41, ETYPE_IPV4, PROTO_UDP, 32'h0A00_0002, cur_vpn);
        send_frame();
        build_frame(42, ETYPE_IPV4, PROTO_UDP, 32'h0A00_0002, cur_vpn);
        send_frame();
        build_frame(53, ETYPE_IPV4, PROTO_TCP, 32'h0A00_0002, cur_tls);
        send_frame();
        build_frame(54, ETYPE_IPV4, PROTO_TCP, 32'h0A00_0002, cur_tls);
        send_frame();
        // tcp to the vpn port and udp to the tls port both pass
        build_frame(60, ETYPE_IPV4, PROTO_TCP, 32'h0A00_0002, cur_vpn);
        send_frame();
        build_frame(60, ETYPE_IPV4, PROTO_UDP, 32'h0A00_0002, cur_tls);
        send_frame();
        // blocked address wins over a matching port
        build_frame(60, ETYPE_IPV4, PROTO_UDP, 32'h0000_0000, cur_vpn);
        send_frame();
        // long frame: position saturates, verdict still at the last byte
        build_frame(100, ETYPE_IPV4, PROTO_TCP, 32'h0A00_0003, cur_tls);
        send_frame();
        // table add in the middle of the destination bytes: served at once
        probe = 32'hC0A8_0A0B;
        build_frame(60, ETYPE_IPV4, PROTO_ICMP, probe, 16'h0000);
        send_frame_span(0, 32);
        issue_table(REQ_ADD, probe);
        send_frame_span(32, 60);
        issue_table(REQ_REMOVE, probe);
        issue_table(REQ_REMOVE, 32'h0000_0000);

        // random traffic under several port settings, extremes included
        run_random(RANDOM_ITEMS / 4);
        quiesce();
        program_ports(16'h0000, 16'h0000);
        run_random(RANDOM_ITEMS / 4);
        quiesce();
        program_ports(16'hFFFF, 16'hFFFF);
        run_random(RANDOM_ITEMS / 4);
        quiesce();
        same_port = 16'($urandom);
        program_ports(16'($urandom), same_port);
        run_random(RANDOM_ITEMS / 8);
        quiesce();
        program_ports(same_port, same_port);
        run_random(RANDOM_ITEMS / 8);

        // full table: empty it of pooled addresses, then fill to the brim
        quiesce();
        steady    = 1'b1;
        fill_salt = $urandom;
        foreach (addr_pool[i])
            issue_table(REQ_REMOVE, addr_pool[i]);
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
            issue_table(REQ_ADD, fill_addr(k));
        // already held while full still reports done
        issue_table(REQ_ADD, fill_addr(7));
        build_frame(60, ETYPE_IPV4, PROTO_UDP, fill_addr(3), cur_vpn);
        send_frame();
        build_frame(60, ETYPE_IPV4, PROTO_TCP, fill_addr(TABLE_DEPTH + 1), cur_tls);
        send_frame();
        // free one slot and refill it, then hit the limit again
        issue_table(REQ_REMOVE, fill_addr(3));
        issue_table(REQ_ADD, fill_addr(TABLE_DEPTH));
        issue_table(REQ_ADD, fill_addr(TABLE_DEPTH + 1));

        quiesce();
        // room for a stray result from the slowest lookup
        repeat (TABLE_DEPTH + SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
